>>> rtl/core/plc_pkg.sv
// Shared types, codes and the palette packing function for the color lookup block.
package plc_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 256;

    localparam logic [7:0] MASK_TOP5 = 8'hF8;
    localparam logic [7:0] MASK_TOP6 = 8'hFC;

    typedef enum logic [1:0] {
        FMT_RGB565       = 2'd0,
        FMT_RGB555       = 2'd1,
        FMT_RGB888_BYTES = 2'd2,
        FMT_RGB888_WORD  = 2'd3
    } fmt_t;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        CFG_SCREEN_FORMAT = 1'b0,
        CFG_PALETTE_VALID = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [23:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic       take;
        logic       in_range;
        logic       frame_end;
    } lookup_t;

    function automatic logic [23:0] pack_color(fmt_t fmt, logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b);
        logic [23:0] word;
        unique case (fmt)
            FMT_RGB565: word = 24'({r & MASK_TOP5, 8'b0}) | 24'({g & MASK_TOP6, 3'b0})
                             | 24'((b & MASK_TOP5) >> 3);
            FMT_RGB555: word = 24'({r & MASK_TOP5, 7'b0}) | 24'({g & MASK_TOP5, 2'b0})
                             | 24'((b & MASK_TOP5) >> 3);
            default:    word = {r, g, b};
        endcase
        return word;
    endfunction

endpackage

>>> rtl/core/plc_table.sv
// Palette memory with per-entry valid bits and a registered read port.
module plc_table
    import plc_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  tbl_wr_t     wr,
    input  logic        rd_en,
    input  logic [7:0]  rd_addr,
    output logic [23:0] rd_data,
    output logic        rd_hit
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [23:0]              mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] vld_reg;
    logic [23:0]              rd_data_reg;
    logic                     rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[IDX_W-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[IDX_W-1:0]];
        end
    end

    // An entry never written since reset reads with rd_hit low.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr[IDX_W-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= vld_reg[rd_addr[IDX_W-1:0]];
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

>>> rtl/core/plc_serial.sv
// Lookup stage and output register that sends one word or three bytes per pixel.
module plc_serial
    import plc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lookup_t     lookup,
    output logic        lookup_ready,
    input  logic [23:0] rd_data,
    input  logic        rd_hit,
    input  logic        palette_valid,
    input  fmt_t        fmt,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data,
    output logic        last_of_pixel,
    output logic        frame_end_out
);

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_range_reg, s1_range_next;
    logic        s1_fe_reg, s1_fe_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] word_reg, word_next;
    fmt_t        fmt_reg, fmt_next;
    logic        fe_reg, fe_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic        out_last;
    logic        out_free;
    logic        s1_move;
    logic [23:0] word_in;

    assign out_last     = (fmt_reg != FMT_RGB888_BYTES) || (cnt_reg == 2'd2);
    assign out_free     = !out_valid_reg || (out_ready && out_last);
    assign s1_move      = s1_valid_reg && out_free;
    assign lookup_ready = !s1_valid_reg || s1_move;
    assign word_in      = (palette_valid && s1_range_reg && rd_hit) ? rd_data : 24'd0;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_range_next  = s1_range_reg;
        s1_fe_next     = s1_fe_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        fmt_next       = fmt_reg;
        fe_next        = fe_reg;
        cnt_next       = cnt_reg;

        if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (lookup.take)
        begin
            s1_valid_next = 1'b1;
            s1_range_next = lookup.in_range;
            s1_fe_next    = lookup.frame_end;
        end

        if (s1_move)
        begin
            out_valid_next = 1'b1;
            word_next      = word_in;
            fmt_next       = fmt;
            fe_next        = s1_fe_reg;
            cnt_next       = 2'd0;
        end
        else if (out_valid_reg && out_ready)
        begin
            if (out_last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 2'd0;
            fmt_reg       <= FMT_RGB565;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            fmt_reg       <= fmt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_range_reg <= s1_range_next;
        s1_fe_reg    <= s1_fe_next;
        word_reg     <= word_next;
        fe_reg       <= fe_next;
    end

    always_comb
    begin
        unique case (fmt_reg)
            FMT_RGB888_BYTES:
            begin
                unique case (cnt_reg)
                    2'd0:    out_data = {24'd0, word_reg[7:0]};
                    2'd1:    out_data = {24'd0, word_reg[15:8]};
                    default: out_data = {24'd0, word_reg[23:16]};
                endcase
            end
            FMT_RGB888_WORD: out_data = {8'd0, word_reg};
            default:         out_data = {16'd0, word_reg[15:0]};
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign last_of_pixel = out_last;
    assign frame_end_out = out_last && fe_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cnt_reg != 2'd3))
        else $error("Byte counter went past the third byte.");

    a_cnt_word_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fmt_reg != FMT_RGB888_BYTES) |-> (cnt_reg == 2'd0))
        else $error("Byte counter moved in a single-beat format.");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        lookup.take |-> lookup_ready)
        else $error("Pixel taken while the lookup stage was held.");

    a_held_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> s1_valid_reg)
        else $error("Held lookup was dropped.");

endmodule

>>> rtl/core/palette_color_lookup.sv
// Top level of the palette color lookup: configuration registers and input decode.
//
//  Channel  | Signals                                                  | Direction
//  ---------+----------------------------------------------------------+----------
//  in       | in_valid, in_ready, opcode, pixel_index, entry_index,    | sink
//           | red_in, green_in, blue_in, frame_end_in                  |
//  out      | out_valid, out_ready, out_data, last_of_pixel,           | source
//           | frame_end_out                                            |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data                | sink
//
// A palette write produces no beat.
// A pixel reads the palette memory as it is accepted and then passes from the lookup stage
// to the output register when that register is free; in 16-bit and 32-bit formats one pixel
// per cycle is sustained while out_ready stays high. In 24-bit format each pixel occupies
// the output register for three beats; the byte serializer loads the next on the last beat.
// Reset clears the configuration and all palette valid bits at once; no clearing pass.
// A stalled output holds the lookup stage, which then holds the input.
module palette_color_lookup
    import plc_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  pixel_index,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        frame_end_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data,
    output logic        last_of_pixel,
    output logic        frame_end_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    fmt_t    fmt_reg;
    logic    pal_valid_reg;
    logic    in_take;
    logic    lookup_ready;
    tbl_wr_t wr;
    lookup_t lookup;
    logic [23:0] rd_data;
    logic        rd_hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_RGB565;
            pal_valid_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SCREEN_FORMAT: fmt_reg       <= fmt_t'(cfg_data);
                CFG_PALETTE_VALID: pal_valid_reg <= cfg_data[0];
            endcase
        end
    end

    assign in_ready = lookup_ready;
    assign in_take  = in_valid && lookup_ready;

    assign wr.en   = in_take && (op_t'(opcode) == OP_WRITE)
                   && ({1'b0, entry_index} < 9'(TABLE_ENTRIES));
    assign wr.addr = entry_index;
    assign wr.data = pack_color(fmt_reg, red_in, green_in, blue_in);

    assign lookup.take      = in_take && (op_t'(opcode) == OP_PIXEL);
    assign lookup.in_range  = ({1'b0, pixel_index} < 9'(TABLE_ENTRIES));
    assign lookup.frame_end = frame_end_in;

    plc_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .rd_en  (lookup.take),
        .rd_addr(pixel_index),
        .rd_data(rd_data),
        .rd_hit (rd_hit)
    );

    plc_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup       (lookup),
        .lookup_ready (lookup_ready),
        .rd_data      (rd_data),
        .rd_hit       (rd_hit),
        .palette_valid(pal_valid_reg),
        .fmt          (fmt_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .last_of_pixel(last_of_pixel),
        .frame_end_out(frame_end_out)
    );

endmodule

>>> test/testbench.sv
// Testbench for palette_color_lookup: directed and random palette traffic checked beat by beat.
module testbench;
    import plc_pkg::*;

    localparam int PALETTE_SIZE = DEFAULT_TABLE_ENTRIES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_CYCLES = 200;

    typedef struct {
        logic [31:0] data;
        logic        last;
        logic        frame_end;
    } color_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [7:0]  pixel_index;
    logic [7:0]  entry_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        frame_end_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_data;
    logic        last_of_pixel;
    logic        frame_end_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [1:0]  cfg_data;

    logic [23:0] palette_words [PALETTE_SIZE];
    fmt_t        format_now;
    logic        attached_now;
    color_beat_t pending_colors [$];
    color_beat_t oldest_color;
    int          mismatches;
    int          cycle_count;
    bit          input_gaps_on;
    bit          output_stalls_on;
    bit          hold_request;

    palette_color_lookup u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .pixel_index   (pixel_index),
        .entry_index   (entry_index),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .frame_end_in  (frame_end_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .last_of_pixel (last_of_pixel),
        .frame_end_out (frame_end_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [23:0] encode_entry(fmt_t fmt, logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b);
        if (fmt == FMT_RGB565)
            return {8'b0, r[7:3], g[7:2], b[7:3]};
        if (fmt == FMT_RGB555)
            return {9'b0, r[7:3], g[7:3], b[7:3]};
        return {r, g, b};
    endfunction

    function automatic void push_color(logic [31:0] data, logic last, logic frame_end);
        color_beat_t beat;
        beat.data = data;
        beat.last = last;
        beat.frame_end = frame_end;
        pending_colors.push_back(beat);
    endfunction

    function automatic void predict_lookup(op_t op, logic [7:0] pix, logic [7:0] ent,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic fe);
        logic [23:0] word;
        if (op == OP_WRITE)
        begin
            if (int'(ent) < PALETTE_SIZE)
                palette_words[ent] = encode_entry(format_now, r, g, b);
            return;
        end
        word = (attached_now && int'(pix) < PALETTE_SIZE) ? palette_words[pix] : 24'h0;
        unique case (format_now)
            FMT_RGB888_BYTES:
            begin
                push_color({24'h0, word[7:0]}, 1'b0, 1'b0);
                push_color({24'h0, word[15:8]}, 1'b0, 1'b0);
                push_color({24'h0, word[23:16]}, 1'b1, fe);
            end
            FMT_RGB888_WORD: push_color({8'h0, word}, 1'b1, fe);
            default:         push_color({16'h0, word[15:0]}, 1'b1, fe);
        endcase
    endfunction

    task automatic send_item(op_t op, logic [7:0] pix, logic [7:0] ent, logic [7:0] r,
                             logic [7:0] g, logic [7:0] b, logic fe);
        @(negedge clk);
        if (input_gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid = 1'b1;
        opcode = op;
        pixel_index = pix;
        entry_index = ent;
        red_in = r;
        green_in = g;
        blue_in = b;
        frame_end_in = fe;
        do
            @(posedge clk);
        while (!in_ready);
        predict_lookup(op, pix, ent, r, g, b, fe);
    endtask

    task automatic write_entry(logic [7:0] ent, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_item(OP_WRITE, 8'($urandom), ent, r, g, b, 1'($urandom));
    endtask

    task automatic read_pixel(logic [7:0] pix, logic fe);
        send_item(OP_PIXEL, pix, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), fe);
    endtask

    task automatic send_random_item();
        op_t        op;
        logic [7:0] idx;
        op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_PIXEL;
        idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        if (op == OP_WRITE)
            send_item(op, 8'($urandom), idx, 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
        else
            send_item(op, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
    endtask

    task automatic wait_idle(int settle);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SCREEN_FORMAT)
            format_now = fmt_t'(value);
        else
            attached_now = value[0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (output_stalls_on && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("unexpected beat: out_data %h", out_data);
                mismatches++;
            end
            else
            begin
                oldest_color = pending_colors.pop_front();
                if (out_data !== oldest_color.data)
                begin
                    $error("out_data: expected %h, actual %h", oldest_color.data, out_data);
                    mismatches++;
                end
                if (last_of_pixel !== oldest_color.last)
                begin
                    $error("last_of_pixel: expected %b, actual %b", oldest_color.last,
                           last_of_pixel);
                    mismatches++;
                end
                if (frame_end_out !== oldest_color.frame_end)
                begin
                    $error("frame_end_out: expected %b, actual %b", oldest_color.frame_end,
                           frame_end_out);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_cleared_table();
        read_pixel(8'd0, 1'b0);
        read_pixel(8'd255, 1'b1);
        wait_idle(8);
        write_register(CFG_PALETTE_VALID, 2'd1);
        read_pixel(8'd255, 1'b0);
        read_pixel(8'd0, 1'b1);
    endtask

    task automatic test_packing_formats();
        for (int f = 0; f < 4; f++)
        begin
            wait_idle(8);
            write_register(CFG_SCREEN_FORMAT, 2'(f));
            write_entry(8'd0, 8'hFF, 8'hFF, 8'hFF);
            write_entry(8'd255, 8'hA5, 8'h5A, 8'h0F);
            read_pixel(8'd0, 1'b0);
            read_pixel(8'd255, 1'b1);
        end
    endtask

    task automatic test_palette_detached();
        wait_idle(8);
        write_register(CFG_SCREEN_FORMAT, FMT_RGB888_BYTES);
        write_register(CFG_PALETTE_VALID, 2'd0);
        read_pixel(8'd255, 1'b1);
        wait_idle(8);
        write_register(CFG_PALETTE_VALID, 2'd1);
    endtask

    task automatic test_format_change();
        write_entry(8'd7, 8'h12, 8'h34, 8'h56);
        wait_idle(8);
        write_register(CFG_SCREEN_FORMAT, FMT_RGB565);
        read_pixel(8'd7, 1'b1);
        wait_idle(8);
        write_register(CFG_SCREEN_FORMAT, FMT_RGB888_BYTES);
        read_pixel(8'd255, 1'b0);
    endtask

    task automatic test_output_stall();
        wait_idle(8);
        write_register(CFG_SCREEN_FORMAT, FMT_RGB565);
        hold_request = 1'b1;
        repeat (24) read_pixel(8'($urandom), 1'($urandom));
    endtask

    task automatic test_random_traffic();
        fmt_t formats [7] = '{FMT_RGB888_WORD, FMT_RGB565, FMT_RGB888_BYTES, FMT_RGB555,
                              FMT_RGB888_BYTES, FMT_RGB565, FMT_RGB888_WORD};
        bit   attached [7] = '{1, 1, 1, 1, 0, 0, 1};
        for (int p = 0; p < 7; p++)
        begin
            wait_idle(8);
            write_register(CFG_SCREEN_FORMAT, formats[p]);
            write_register(CFG_PALETTE_VALID, {1'b0, attached[p]});
            input_gaps_on = (p != 6);
            output_stalls_on = (p != 6);
            for (int n = 0; n < 48; n++)
            begin
                // Pause the input mid-phase until every beat has come out.
                if (n == 24 && p == 2)
                    wait_idle(0);
                send_random_item();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_PIXEL;
        pixel_index = 8'h0;
        entry_index = 8'h0;
        red_in = 8'h0;
        green_in = 8'h0;
        blue_in = 8'h0;
        frame_end_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCREEN_FORMAT;
        cfg_data = 2'd0;
        format_now = FMT_RGB565;
        attached_now = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        input_gaps_on = 1'b1;
        output_stalls_on = 1'b1;
        hold_request = 1'b0;
        for (int i = 0; i < PALETTE_SIZE; i++)
            palette_words[i] = 24'h0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_cleared_table();
        test_packing_formats();
        test_palette_detached();
        test_format_change();
        test_output_stall();
        test_random_traffic();

        wait_idle(20);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
